// ===== rtl/pfi_pkg.sv =====
// ----------------------------------------------------------------------------
// pfi_pkg
// shared types and widths of the palette fade interpolator
// ----------------------------------------------------------------------------
package pfi_pkg;

    localparam int CH_W      = 6;   // one color channel
    localparam int IDX_W     = 8;   // palette entry index
    localparam int STEP_W    = 12;  // step number and step count
    localparam int PROD_W    = 18;  // step times channel difference
    localparam int QUO_W     = 6;   // quotient bits, one per divider cell
    localparam int NUM_CH    = 3;   // red, green, blue
    localparam int MAX_TABLE = 64;  // table entries reachable by a 6-bit channel

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_FADE = 1'b1
    } pfi_op_t;

    // per-channel divider state carried along the cell chain
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic              neg;
        logic [CH_W-1:0]   from;
    } pfi_chan_t;

    typedef struct packed {
        logic                   valid;
        pfi_op_t                op;
        logic [IDX_W-1:0]       index;
        logic [CH_W-1:0]        tval;
        pfi_chan_t [NUM_CH-1:0] chan;
    } pfi_word_t;

endpackage

// ===== rtl/pfi_ram.sv =====
// ----------------------------------------------------------------------------
// pfi_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module pfi_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pfi_div_cell.sv =====
// ----------------------------------------------------------------------------
// pfi_div_cell
// one restoring division step for all three channels, one quotient bit
// ----------------------------------------------------------------------------
module pfi_div_cell
    import pfi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [STEP_W-1:0] divisor,
    input  pfi_word_t         word_in,
    output pfi_word_t         word_out
);

    pfi_word_t         word_reg;
    pfi_word_t         word_next;
    logic [PROD_W-1:0] div_shifted;

    // divisor aligned to the top quotient bit
    assign div_shifted = {1'b0, divisor, {(QUO_W-1){1'b0}}};

    always_comb begin
        logic              ge;
        logic [PROD_W-1:0] rem_sub;
        word_next = word_in;
        for (int c = 0; c < NUM_CH; c++) begin
            ge      = (word_in.chan[c].rem >= div_shifted);
            rem_sub = ge ? (word_in.chan[c].rem - div_shifted) : word_in.chan[c].rem;
            word_next.chan[c].rem = {rem_sub[PROD_W-2:0], 1'b0};
            word_next.chan[c].quo = {word_in.chan[c].quo[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (en) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== rtl/palette_fade_interpolator.sv =====
// ----------------------------------------------------------------------------
// palette_fade_interpolator
// linear palette fade with brightness table lookup
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and gives one
// result per fade word. A fade word computes, per channel, from - (s *
// (from - to)) / step_count with s the step number saturated to step_count
// and a signed division that truncates toward zero, then maps the value
// through the brightness table. The division runs through a chain of six
// identical cells, one quotient bit each. A load word writes one table entry
// at the point where fade words read it, so loads and fades keep their order,
// and gives no result. The table comes out of reset as the identity map
// (per-entry valid flags, no clearing pass). The user must write step_count
// only while no word is in flight; the block does not enforce this. A value
// of zero acts as one.
// ----------------------------------------------------------------------------
module palette_fade_interpolator
    import pfi_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int CHANNEL_LEVELS  = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // step count register
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data,
    // input words
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [IDX_W-1:0]  s_entry_index,
    input  logic [CH_W-1:0]   s_from_red,
    input  logic [CH_W-1:0]   s_from_green,
    input  logic [CH_W-1:0]   s_from_blue,
    input  logic [CH_W-1:0]   s_to_red,
    input  logic [CH_W-1:0]   s_to_green,
    input  logic [CH_W-1:0]   s_to_blue,
    input  logic [STEP_W-1:0] s_step_number,
    input  logic [CH_W-1:0]   s_table_value,
    // result words
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_out_index,
    output logic [CH_W-1:0]   m_out_red,
    output logic [CH_W-1:0]   m_out_green,
    output logic [CH_W-1:0]   m_out_blue
);

    // only the first 64 entries can ever be written or looked up
    localparam int TABLE_DEPTH = (CHANNEL_LEVELS < MAX_TABLE) ? CHANNEL_LEVELS : MAX_TABLE;
    localparam int TADDR_W     = $clog2(TABLE_DEPTH);
    localparam int LVL_W       = 9;

    typedef struct packed {
        pfi_op_t                      op;
        logic [IDX_W-1:0]             index;
        logic [NUM_CH-1:0][CH_W-1:0]  from;
        logic [NUM_CH-1:0][CH_W-1:0]  to;
        logic [STEP_W-1:0]            step;
        logic [CH_W-1:0]              tval;
    } in_word_t;

    typedef struct packed {
        logic                         valid;
        pfi_op_t                      op;
        logic [IDX_W-1:0]             index;
        logic [CH_W-1:0]              tval;
        logic [STEP_W-1:0]            step;
        logic [NUM_CH-1:0]            neg;
        logic [NUM_CH-1:0][CH_W-1:0]  from;
        logic [NUM_CH-1:0][CH_W-1:0]  absd;
    } front_t;

    // step count register, zero folded to one at write time
    logic [STEP_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= STEP_W'(1);
        end else if (cfg_wr_en) begin
            cnt_reg <= (cfg_wr_data == '0) ? STEP_W'(1) : cfg_wr_data;
        end
    end

    // pipeline advances whenever the output register can take a word
    logic en;
    logic m_valid_reg;

    assign en = !m_valid_reg || m_ready;

    // input skid stage: ready comes from a register, not from m_ready
    in_word_t in_word;
    in_word_t skid_reg;
    in_word_t src_word;
    logic     skid_valid_reg;
    logic     in_acc;
    logic     src_valid;

    assign in_word = '{op:    pfi_op_t'(s_opcode),
                       index: s_entry_index,
                       from:  {s_from_blue, s_from_green, s_from_red},
                       to:    {s_to_blue, s_to_green, s_to_red},
                       step:  s_step_number,
                       tval:  s_table_value};

    assign s_ready   = !skid_valid_reg;
    assign in_acc    = s_valid && s_ready;
    assign src_valid = skid_valid_reg || in_acc;
    assign src_word  = skid_valid_reg ? skid_reg : in_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && in_acc) begin
            skid_reg <= in_word;
        end
    end

    // front stage: saturate the step, split each difference into sign and magnitude
    front_t a_reg;
    front_t a_next;

    always_comb begin
        a_next.valid = src_valid;
        a_next.op    = src_word.op;
        a_next.index = src_word.index;
        a_next.tval  = src_word.tval;
        a_next.step  = (src_word.step > cnt_reg) ? cnt_reg : src_word.step;
        a_next.from  = src_word.from;
        for (int c = 0; c < NUM_CH; c++) begin
            a_next.neg[c]  = (src_word.from[c] < src_word.to[c]);
            a_next.absd[c] = a_next.neg[c] ? (src_word.to[c] - src_word.from[c])
                                           : (src_word.from[c] - src_word.to[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.valid <= 1'b0;
        end else if (en) begin
            a_reg <= a_next;
        end
    end

    // product stage: |step * diff| is the dividend, below 2^18
    pfi_word_t b_reg;
    pfi_word_t b_next;

    always_comb begin
        b_next.valid = a_reg.valid;
        b_next.op    = a_reg.op;
        b_next.index = a_reg.index;
        b_next.tval  = a_reg.tval;
        for (int c = 0; c < NUM_CH; c++) begin
            b_next.chan[c].rem  = PROD_W'(a_reg.step) * PROD_W'(a_reg.absd[c]);
            b_next.chan[c].quo  = '0;
            b_next.chan[c].neg  = a_reg.neg[c];
            b_next.chan[c].from = a_reg.from[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.valid <= 1'b0;
        end else if (en) begin
            b_reg <= b_next;
        end
    end

    // divider chain: since s <= step_count the quotient never exceeds 63,
    // so six cells give the whole quotient
    pfi_word_t chain [QUO_W+1];

    assign chain[0] = b_reg;

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        pfi_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .divisor  (cnt_reg),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    pfi_word_t last;

    assign last = chain[QUO_W];

    // lookup stage: apply the sign, clamp to the table, address the table
    logic [NUM_CH-1:0][TADDR_W-1:0] rd_addr;
    logic [NUM_CH-1:0][CH_W-1:0]    rst_val;

    always_comb begin
        logic [CH_W:0]    v;
        logic [LVL_W-1:0] lvl;
        for (int c = 0; c < NUM_CH; c++) begin
            v = last.chan[c].neg ? ({1'b0, last.chan[c].from} + {1'b0, last.chan[c].quo})
                                 : ({1'b0, last.chan[c].from} - {1'b0, last.chan[c].quo});
            lvl = LVL_W'(v);
            if (lvl >= LVL_W'(CHANNEL_LEVELS)) begin
                lvl = LVL_W'(CHANNEL_LEVELS - 1);
            end
            rd_addr[c] = lvl[TADDR_W-1:0];
            rst_val[c] = lvl[CH_W-1:0];
        end
    end

    // table writes happen at the lookup point so a later fade sees them
    logic [CH_W-1:0] ld_idx;
    logic            ld_ok;
    logic            tbl_wr;

    assign ld_idx = last.index[CH_W-1:0];
    assign ld_ok  = last.valid && (last.op == OP_LOAD)
                    && (LVL_W'(ld_idx) < LVL_W'(CHANNEL_LEVELS));
    assign tbl_wr = en && ld_ok;

    // written flags: an unwritten entry reads as its own index
    logic [TABLE_DEPTH-1:0] tv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= '0;
        end else if (tbl_wr) begin
            tv_reg[ld_idx[TADDR_W-1:0]] <= 1'b1;
        end
    end

    // one table copy per channel, all written together
    logic [NUM_CH-1:0][CH_W-1:0] rd_data;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_table
        pfi_ram #(
            .WIDTH (CH_W),
            .DEPTH (TABLE_DEPTH)
        ) u_table (
            .aclk    (aclk),
            .wr_en   (tbl_wr),
            .wr_addr (ld_idx[TADDR_W-1:0]),
            .wr_data (last.tval),
            .rd_en   (en),
            .rd_addr (rd_addr[c]),
            .rd_data (rd_data[c])
        );
    end

    // palette index wrap, a constant table
    logic [IDX_W-1:0] mod_lut [2**IDX_W];

    for (genvar i = 0; i < 2**IDX_W; i++) begin : g_mod
        assign mod_lut[i] = IDX_W'(i % PALETTE_ENTRIES);
    end

    // output register, aligned with the table read data
    logic [IDX_W-1:0]            m_index_reg;
    logic [NUM_CH-1:0]           hit_reg;
    logic [NUM_CH-1:0][CH_W-1:0] rst_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.valid && (last.op == OP_FADE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_index_reg <= mod_lut[last.index];
            for (int c = 0; c < NUM_CH; c++) begin
                hit_reg[c] <= tv_reg[rd_addr[c]];
                rst_reg[c] <= rst_val[c];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = m_index_reg;
    assign m_out_red   = hit_reg[0] ? rd_data[0] : rst_reg[0];
    assign m_out_green = hit_reg[1] ? rd_data[1] : rst_reg[1];
    assign m_out_blue  = hit_reg[2] ? rd_data[2] : rst_reg[2];

endmodule

// ===== tb/tb_palette_fade_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_fade_interpolator
// self-checking bench for the palette fade interpolator
// ----------------------------------------------------------------------------
// Drives load and fade words through the valid/ready input and keeps its own
// copy of the brightness table and step count to work out every faded color.
// Results are compared field by field, in order, with the oldest pending
// color. A short directed table covers the corners (zero step, full step,
// step past the count, zero count, truncation of negative quotients, table
// index taken from the low six bits); random phases at several step counts
// follow, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_palette_fade_interpolator;
    import pfi_pkg::*;

    localparam int PAL_ENTRIES     = 256;
    localparam int LEVELS          = 64;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 20;     // covers the pipeline latency with margin
    localparam int HOLD_CYCLES     = 300;    // long output stall, fills the pipe
    localparam int HOLD_AFTER      = 40;     // results seen before the stall
    localparam int RAND_PHASES     = 6;
    localparam int WORDS_PER_PHASE = 84;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_PRINTED     = 40;

    // one input word, split the way the ports are
    typedef struct packed {
        pfi_op_t           op;
        logic [IDX_W-1:0]  index;
        logic [CH_W-1:0]   from_r;
        logic [CH_W-1:0]   from_g;
        logic [CH_W-1:0]   from_b;
        logic [CH_W-1:0]   to_r;
        logic [CH_W-1:0]   to_g;
        logic [CH_W-1:0]   to_b;
        logic [STEP_W-1:0] step;
        logic [CH_W-1:0]   tval;
    } fade_word_t;

    // one faded palette entry
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } color_t;

    // directed rows: a step count write, a load, a fade checked by the
    // predictor, or a fade with its color typed in
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_FADE,
        ROW_FADE_CHK
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [STEP_W-1:0] cfg_val;
        fade_word_t        w;
        color_t            want;
    } row_t;

    // ports, all inputs known from time zero
    logic              aclk;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [STEP_W-1:0] cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_opcode      = 1'b0;
    logic [IDX_W-1:0]  s_entry_index = '0;
    logic [CH_W-1:0]   s_from_red    = '0;
    logic [CH_W-1:0]   s_from_green  = '0;
    logic [CH_W-1:0]   s_from_blue   = '0;
    logic [CH_W-1:0]   s_to_red      = '0;
    logic [CH_W-1:0]   s_to_green    = '0;
    logic [CH_W-1:0]   s_to_blue     = '0;
    logic [STEP_W-1:0] s_step_number = '0;
    logic [CH_W-1:0]   s_table_value = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [IDX_W-1:0]  m_out_index;
    logic [CH_W-1:0]   m_out_red;
    logic [CH_W-1:0]   m_out_green;
    logic [CH_W-1:0]   m_out_blue;

    // predictor state: brightness table and step count as the block holds them
    logic [CH_W-1:0]   gamma_lut [LEVELS];
    logic [STEP_W-1:0] step_count_q;

    color_t pending_colors [$];
    row_t   dir_rows [$];

    int errors    = 0;
    int n_loads   = 0;
    int n_fades   = 0;
    int n_checked = 0;
    int n_cfg     = 0;
    int cycle_cnt = 0;
    bit hold_done = 1'b0;

    palette_fade_interpolator #(
        .PALETTE_ENTRIES (PAL_ENTRIES),
        .CHANNEL_LEVELS  (LEVELS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_entry_index (s_entry_index),
        .s_from_red    (s_from_red),
        .s_from_green  (s_from_green),
        .s_from_blue   (s_from_blue),
        .s_to_red      (s_to_red),
        .s_to_green    (s_to_green),
        .s_to_blue     (s_to_blue),
        .s_step_number (s_step_number),
        .s_table_value (s_table_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_index   (m_out_index),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // --------------------------------------------------------------------
    // predictor
    // --------------------------------------------------------------------

    // one channel: from - s*(from-to)/cnt, signed, truncated toward zero,
    // clamped into the table, then looked up
    function automatic logic [CH_W-1:0] faded_level(logic [CH_W-1:0] f,
                                                     logic [CH_W-1:0] t,
                                                     int s, int cnt);
        int prod;
        int v;
        prod = s * (int'(f) - int'(t));
        v = int'(f) - prod / cnt;
        if (v < 0) v = 0;
        if (v >= LEVELS) v = LEVELS - 1;
        return gamma_lut[v[5:0]];
    endfunction

    // loads update the table copy, fades queue their expected color
    task automatic predict_word(fade_word_t w, bit typed, color_t want);
        color_t c;
        int cnt;
        int s;
        if (w.op == OP_LOAD) begin
            // loads past the table are dropped
            if (int'(w.index[5:0]) < LEVELS) gamma_lut[w.index[5:0]] = w.tval;
            n_loads++;
        end else begin
            cnt = (step_count_q == '0) ? 1 : int'(step_count_q);
            s = (int'(w.step) > cnt) ? cnt : int'(w.step);
            c.index = IDX_W'(int'(w.index) % PAL_ENTRIES);
            c.red   = faded_level(w.from_r, w.to_r, s, cnt);
            c.green = faded_level(w.from_g, w.to_g, s, cnt);
            c.blue  = faded_level(w.from_b, w.to_b, s, cnt);
            pending_colors.push_back(typed ? want : c);
            n_fades++;
        end
    endtask

    // --------------------------------------------------------------------
    // input side
    // --------------------------------------------------------------------

    // raise valid with the word and hold it until the edge that takes it
    task automatic send_word(fade_word_t w);
        s_valid       <= 1'b1;
        s_opcode      <= w.op;
        s_entry_index <= w.index;
        s_from_red    <= w.from_r;
        s_from_green  <= w.from_g;
        s_from_blue   <= w.from_b;
        s_to_red      <= w.to_r;
        s_to_green    <= w.to_g;
        s_to_blue     <= w.to_b;
        s_step_number <= w.step;
        s_table_value <= w.tval;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    // valid only drops when a real gap follows, so it never toggles in one step
    task automatic idle_after(bit calm);
        int g;
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // step count changes only with the pipe empty; loads leave nothing
    // pending, so give them time to clear before the write
    task automatic write_step_count(logic [STEP_W-1:0] val);
        s_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        step_count_q = val;
        n_cfg++;
    endtask

    function automatic logic [CH_W-1:0] rand_level();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        else if (r == 1) return '1;
        else return CH_W'($urandom);
    endfunction

    function automatic fade_word_t random_word(int cnt);
        fade_word_t w;
        w.op     = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_FADE;
        w.index  = IDX_W'($urandom);
        w.from_r = rand_level();
        w.from_g = rand_level();
        w.from_b = rand_level();
        w.to_r   = rand_level();
        w.to_g   = rand_level();
        w.to_b   = rand_level();
        w.tval   = CH_W'($urandom);
        // steps cluster at zero, at the count, past it, and inside the fade
        case ($urandom_range(0, 9))
            0:          w.step = '0;
            1:          w.step = STEP_W'(cnt);
            2:          w.step = STEP_W'(cnt + $urandom_range(0, 4095 - cnt));
            3, 4, 5, 6: w.step = STEP_W'($urandom_range(0, cnt));
            default:    w.step = STEP_W'($urandom);
        endcase
        return w;
    endfunction

    // --------------------------------------------------------------------
    // directed table
    // --------------------------------------------------------------------

    task automatic add_cfg(logic [STEP_W-1:0] val);
        row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.cfg_val = val;
        dir_rows.push_back(r);
    endtask

    task automatic add_load(logic [IDX_W-1:0] idx, logic [CH_W-1:0] val);
        row_t r;
        r         = '0;
        r.kind    = ROW_LOAD;
        r.w.op    = OP_LOAD;
        r.w.index = idx;
        r.w.tval  = val;
        r.w.step  = STEP_W'($urandom);
        dir_rows.push_back(r);
    endtask

    task automatic add_fade(bit typed, logic [IDX_W-1:0] idx,
                            logic [3*CH_W-1:0] from_rgb, logic [3*CH_W-1:0] to_rgb,
                            logic [STEP_W-1:0] step, logic [3*CH_W-1:0] want_rgb);
        row_t r;
        r         = '0;
        r.kind    = typed ? ROW_FADE_CHK : ROW_FADE;
        r.w.op    = OP_FADE;
        r.w.index = idx;
        r.w.step  = step;
        r.w.tval  = CH_W'($urandom);
        {r.w.from_r, r.w.from_g, r.w.from_b} = from_rgb;
        {r.w.to_r, r.w.to_g, r.w.to_b}       = to_rgb;
        r.want = {idx, want_rgb};
        dir_rows.push_back(r);
    endtask

    // --------------------------------------------------------------------
    // output side
    // --------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // every taken result against the oldest pending color
    always @(posedge aclk) begin
        color_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_colors.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_out_index), 0);
            end else begin
                want = pending_colors.pop_front();
                if (m_out_index !== want.index)
                    report_mismatch("out_index", int'(m_out_index), int'(want.index));
                if (m_out_red !== want.red)
                    report_mismatch("out_red", int'(m_out_red), int'(want.red));
                if (m_out_green !== want.green)
                    report_mismatch("out_green", int'(m_out_green), int'(want.green));
                if (m_out_blue !== want.blue)
                    report_mismatch("out_blue", int'(m_out_blue), int'(want.blue));
                n_checked++;
            end
        end
    end

    // ready with random stalls, calm stretches, and one long hold-off
    // while the sender keeps offering words
    initial begin
        int len;
        int rx_left;
        bit rx_calm;
        rx_left = 0;
        rx_calm = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!hold_done && n_checked >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_calm = ($urandom_range(0, 3) == 0);
                    rx_left = $urandom_range(20, 80);
                end
                rx_left--;
                len = rx_calm ? 0 : pick_gap();
                if (len == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (len) @(posedge aclk);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial begin
        row_t       rw;
        fade_word_t w;
        int         cnt;
        bit         calm;
        logic [STEP_W-1:0] phase_step;

        // table comes out of reset as the identity map, step count one
        for (int i = 0; i < LEVELS; i++) gamma_lut[i] = CH_W'(i);
        step_count_q = 12'd1;

        // step count one, identity table
        add_fade(1, 8'd0,   {6'd0, 6'd0, 6'd0},    {6'd63, 6'd63, 6'd63}, 12'd0,
                 {6'd0, 6'd0, 6'd0});               // step zero keeps the start color
        add_fade(1, 8'd255, {6'd63, 6'd63, 6'd63}, {6'd0, 6'd0, 6'd0},    12'd1,
                 {6'd0, 6'd0, 6'd0});               // full step reaches the target
        add_fade(1, 8'd128, {6'd10, 6'd20, 6'd30}, {6'd40, 6'd50, 6'd60}, 12'd4095,
                 {6'd40, 6'd50, 6'd60});            // step past the count saturates
        add_fade(1, 8'h55,  {6'd63, 6'd0, 6'd63},  {6'd0, 6'd63, 6'd0},   12'd0,
                 {6'd63, 6'd0, 6'd63});
        add_fade(1, 8'hAA,  {6'd0, 6'd63, 6'd0},   {6'd63, 6'd0, 6'd63},  12'd2,
                 {6'd63, 6'd0, 6'd63});
        // loads take the table index from the low six bits only
        add_load(8'hFF, 6'd0);
        add_load(8'h40, 6'd63);
        add_load(8'h2A, 6'h15);
        add_load(8'h15, 6'h2A);
        add_fade(0, 8'd1, {6'd63, 6'd0, 6'd42}, {6'd63, 6'd0, 6'd42}, 12'd0, '0);
        add_fade(0, 8'd2, {6'd21, 6'd42, 6'd63}, {6'd0, 6'd0, 6'd0},  12'd1, '0);
        // put the ends of the table back so the typed rows below hold
        add_load(8'h3F, 6'd63);
        add_load(8'h00, 6'd0);
        // zero step count behaves as one
        add_cfg(12'd0);
        add_fade(1, 8'd3, {6'd5, 6'd6, 6'd7}, {6'd60, 6'd61, 6'd62}, 12'd1,
                 {6'd60, 6'd61, 6'd62});
        add_fade(1, 8'd4, {6'd5, 6'd6, 6'd7}, {6'd60, 6'd61, 6'd62}, 12'd0,
                 {6'd5, 6'd6, 6'd7});
        // largest step count
        add_cfg(12'd4095);
        add_fade(1, 8'd5, {6'd0, 6'd63, 6'd31}, {6'd63, 6'd0, 6'd32}, 12'd4095,
                 {6'd63, 6'd0, 6'd32});
        add_fade(0, 8'd6, {6'd0, 6'd63, 6'd31}, {6'd63, 6'd0, 6'd32}, 12'd2048, '0);
        add_fade(0, 8'd7, {6'd0, 6'd63, 6'd0},  {6'd63, 6'd0, 6'd63}, 12'd4094, '0);
        // odd divisor: quotients of both signs truncate toward zero
        add_cfg(12'd3);
        add_fade(0, 8'd8,  {6'd63, 6'd0, 6'd1}, {6'd0, 6'd62, 6'd0},  12'd1, '0);
        add_fade(0, 8'd9,  {6'd1, 6'd0, 6'd63}, {6'd0, 6'd1, 6'd0},   12'd2, '0);
        add_fade(0, 8'd10, {6'd0, 6'd0, 6'd0},  {6'd63, 6'd63, 6'd63}, 12'd3000, '0);

        // hold the synchronous reset, then release it
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            rw = dir_rows[k];
            if (rw.kind == ROW_CFG) begin
                write_step_count(rw.cfg_val);
            end else begin
                send_word(rw.w);
                predict_word(rw.w, rw.kind == ROW_FADE_CHK, rw.want);
                idle_after(1'b0);
            end
        end

        // random phases, each at its own step count
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       phase_step = 12'd1;
                1:       phase_step = 12'd4095;
                2:       phase_step = STEP_W'($urandom_range(2, 8));
                3:       phase_step = STEP_W'($urandom_range(9, 4094));
                4:       phase_step = 12'd2;
                default: phase_step = STEP_W'($urandom_range(1, 64));
            endcase
            write_step_count(phase_step);
            cnt = (step_count_q == '0) ? 1 : int'(step_count_q);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                // every third stretch of words goes back to back
                calm = ((i / 24) % 3 == 1);
                w = random_word(cnt);
                send_word(w);
                predict_word(w, 1'b0, '0);
                idle_after(calm);
            end
        end

        // drain, then let any stray result show up
        s_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d fade words and %0d table loads over %0d step count settings",
                 n_fades, n_loads, n_cfg);
        $display("%0d results compared, output held off once for %0d cycles",
                 n_checked, HOLD_CYCLES);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
